// ----- hw/rtl/crpf_pkg.sv -----
package crpf_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_FRAC = 16;

  localparam logic [16:0] T_ONE = 17'd65536;
  localparam logic [63:0] C_ONE = 64'd1 << COORD_FRAC;
  localparam logic [63:0] ZERO_SQ =
    ((64'd1 << (2 * COORD_FRAC)) + 64'd99999999) / 64'd100000000;
  localparam logic [63:0] MOVE_SQ = (64'd1 << (2 * COORD_FRAC)) / 64'd1000000;

  localparam logic [1:0] REG_SPEED = 2'd0;
  localparam logic [1:0] REG_LOOP  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

endpackage

// ----- hw/rtl/crpf_ram.sv -----
module crpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/catmull_rom_path_follower_top.sv -----
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   op, point_index, point_x, point_z
// out       output     out_valid_o / out_ready_i pos, dir, segment_now, seg_fraction,
//                                                path_active
// config    input      psel, penable, pwrite     paddr, pwdata, prdata (APB)
//
// A point write goes straight into the point memory.
// A tick evaluates the spline and the move length with its 32-step square root,
// plus each segment length it evaluates (two reads of the point memory and a
// 32-step square root), plus one division for a partial step, one for a lap
// reduction and one for each heading part.
// In loop mode the lap length adds point_count length evaluations per tick.
// Reset clears the registers and the path state; the point memory is not
// cleared. A finished beat waits in the output register while new beats are
// taken; a tick that completes while it is still full holds until it leaves.
module catmull_rom_path_follower_top #(
  parameter int MAX_POINTS = crpf_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [5:0]         point_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [17:0] dir_x_o,
  output logic signed [17:0] dir_z_o,
  output logic [5:0]         segment_now_o,
  output logic [16:0]        seg_fraction_o,
  output logic               path_active_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import crpf_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = 34 + AW;
  localparam logic signed [31:0] HMAX = 32'(C_ONE);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_LAP    = 5'd2;
  localparam logic [4:0] S_LAPADD = 5'd3;
  localparam logic [4:0] S_SEG0   = 5'd4;
  localparam logic [4:0] S_SEG1   = 5'd5;
  localparam logic [4:0] S_SEG2   = 5'd6;
  localparam logic [4:0] S_H0     = 5'd7;
  localparam logic [4:0] S_H1     = 5'd8;
  localparam logic [4:0] S_H2     = 5'd9;
  localparam logic [4:0] S_H3     = 5'd10;
  localparam logic [4:0] S_SQ     = 5'd11;
  localparam logic [4:0] S_SEGRET = 5'd12;
  localparam logic [4:0] S_WTOP   = 5'd13;
  localparam logic [4:0] S_MODRET = 5'd14;
  localparam logic [4:0] S_WLEN   = 5'd15;
  localparam logic [4:0] S_WCMP   = 5'd16;
  localparam logic [4:0] S_WPART  = 5'd17;
  localparam logic [4:0] S_ADV    = 5'd18;
  localparam logic [4:0] S_SPLR   = 5'd19;
  localparam logic [4:0] S_COEF   = 5'd20;
  localparam logic [4:0] S_MUL    = 5'd21;
  localparam logic [4:0] S_ACC    = 5'd22;
  localparam logic [4:0] S_SAT    = 5'd23;
  localparam logic [4:0] S_MOVE0  = 5'd24;
  localparam logic [4:0] S_MOVE1  = 5'd25;
  localparam logic [4:0] S_HX     = 5'd26;
  localparam logic [4:0] S_HZ     = 5'd27;
  localparam logic [4:0] S_COMMIT = 5'd28;
  localparam logic [4:0] S_DIV    = 5'd29;
  localparam logic [4:0] S_FIN    = 5'd30;

  function automatic logic [AW-1:0] resolve(input int i, input int nn, input logic lp);
    int r;
    if (lp) begin
      r = (i < 0) ? i + nn : ((i >= nn) ? i - nn : i);
    end else begin
      r = (i < 0) ? 0 : ((i > nn - 1) ? nn - 1 : i);
    end
    return AW'(r);
  endfunction

  // Configuration registers
  logic [30:0] speed_q;
  logic        loop_q;
  logic [6:0]  count_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_SPEED: prdata = {1'b0, speed_q};
      REG_LOOP:  prdata = {31'b0, loop_q};
      REG_COUNT: prdata = {25'b0, count_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      loop_q  <= 1'b0;
      count_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_SPEED: speed_q <= pwdata[30:0];
        REG_LOOP:  loop_q  <= pwdata[0];
        REG_COUNT: count_q <= pwdata[6:0];
        default:   ;
      endcase
    end
  end

  // Point memory, X in the low half and Z in the high half
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;
  logic [4:0]    state_q;
  logic          in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ram_we     = in_acc && (op_i == OP_WRITE) && (int'(point_index_i) < MAX_POINTS);

  crpf_ram #(
    .WIDTH(64),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(point_index_i)),
    .wdata_i({point_z_i, point_x_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Path state and working registers
  logic [AW-1:0]      seg_idx_q;
  logic [16:0]        seg_t_q;
  logic signed [31:0] pos_x_q, pos_z_q, head_x_q, head_z_q;
  logic               active_q;
  logic [CW-1:0]      n_q, segc_q, skips_q, lap_i_q;
  logic [30:0]        rem_q;
  logic [LW-1:0]      lap_q;
  logic [33:0]        len_q;
  logic [34:0]        dend_q;
  logic [AW-1:0]      seg_i_q;
  logic [4:0]         seg_ret_q, hyp_ret_q, div_ret_q;
  logic [31:0]        pa_x_q, pa_z_q;
  logic signed [33:0] hx_q, hz_q;
  logic [31:0]        ha_q, hb_q;
  logic               half_q;
  logic [63:0]        sqa_q, sqb_q, hyp_sq_q;
  logic [33:0]        hyp_len_q;
  logic [63:0]        sq_n_q, sq_r_q, sq_b_q;
  logic [4:0]         sq_cnt_q;
  logic [63:0]        div_num_q, div_den_q;
  logic [64:0]        div_rem_q;
  logic [5:0]         div_cnt_q;
  logic [2:0]         rd_cnt_q;
  logic [31:0]        px_q [4];
  logic [31:0]        pz_q [4];
  logic               axis_q;
  logic [1:0]         step_q;
  logic signed [39:0] a_q, b_q, p2x_q, acc_q;
  logic signed [57:0] prod_q;
  logic signed [31:0] nx_q, nz_q, hxn_q;

  logic               out_valid_q;
  logic signed [31:0] out_px_q, out_pz_q;
  logic signed [17:0] out_dx_q, out_dz_q;
  logic [5:0]         out_seg_q;
  logic [16:0]        out_t_q;
  logic               out_act_q;

  // Combinational helpers
  logic [CW-1:0]      nn;
  logic [33:0]        ax, az;
  logic               halve;
  logic [63:0]        sq_trial;
  logic [64:0]        div_try;
  logic [50:0]        wprod;
  logic signed [39:0] q0, q1, q2, q3, coef_a, coef_b, coef_c, addend, half_acc;
  logic signed [31:0] sat_v;
  logic [31:0]        cap_q;
  logic               wrap;

  assign nn = (int'(count_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_q);

  always_comb begin
    case (state_q)
      S_SEG0:  ram_raddr = seg_i_q;
      S_SEG1:  ram_raddr = resolve(int'(seg_i_q) + 1, int'(n_q), loop_q);
      S_SPLR:  ram_raddr = resolve(int'(seg_idx_q) + int'(rd_cnt_q) - 1, int'(n_q), loop_q);
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    ax       = hx_q[33] ? 34'(-hx_q) : 34'(hx_q);
    az       = hz_q[33] ? 34'(-hz_q) : 34'(hz_q);
    halve    = (ax[33:31] != 3'b0) || (az[33:31] != 3'b0);
    sq_trial = sq_r_q + sq_b_q;
    div_try  = {div_rem_q[63:0], div_num_q[63]};
    wprod    = 51'(len_q) * 51'(T_ONE - seg_t_q);
    wrap     = (int'(seg_idx_q) + 1) >= int'(segc_q);
    if (axis_q) begin
      q0 = $signed(pz_q[0]);
      q1 = $signed(pz_q[1]);
      q2 = $signed(pz_q[2]);
      q3 = $signed(pz_q[3]);
    end else begin
      q0 = $signed(px_q[0]);
      q1 = $signed(px_q[1]);
      q2 = $signed(px_q[2]);
      q3 = $signed(px_q[3]);
    end
    coef_a = q2 - q0;
    coef_b = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    coef_c = q1 + (q1 <<< 1) - q2 - (q2 <<< 1) + q3 - q0;
    case (step_q)
      2'd0:    addend = b_q;
      2'd1:    addend = a_q;
      default: addend = p2x_q;
    endcase
    half_acc = acc_q >>> 1;
    if (half_acc > 40'sd2147483647) begin
      sat_v = 32'sh7FFFFFFF;
    end else if (half_acc < -40'sd2147483648) begin
      sat_v = 32'sh80000000;
    end else begin
      sat_v = 32'(half_acc);
    end
    cap_q = (div_num_q > C_ONE) ? 32'(C_ONE) : div_num_q[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      seg_idx_q <= '0;
      seg_t_q   <= '0;
      pos_x_q   <= '0;
      pos_z_q   <= '0;
      head_x_q  <= '0;
      head_z_q  <= HMAX;
      active_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (op_i == OP_TICK)) begin
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          n_q     <= nn;
          segc_q  <= loop_q ? nn : nn - 1'b1;
          rem_q   <= speed_q;
          lap_q   <= '0;
          lap_i_q <= '0;
          skips_q <= '0;
          if (int'(nn) < 2) begin
            active_q <= 1'b0;
            state_q  <= S_FIN;
          end else begin
            active_q <= 1'b1;
            if (int'(seg_idx_q) >= (loop_q ? int'(nn) : int'(nn) - 1)) begin
              seg_idx_q <= '0;
              seg_t_q   <= '0;
            end else if (seg_t_q > T_ONE) begin
              seg_t_q <= T_ONE;
            end
            state_q <= loop_q ? S_LAP : S_WTOP;
          end
        end
        S_LAP: begin
          if (lap_i_q == n_q) begin
            state_q <= S_WTOP;
          end else begin
            seg_i_q   <= AW'(lap_i_q);
            seg_ret_q <= S_LAPADD;
            state_q   <= S_SEG0;
          end
        end
        S_LAPADD: begin
          lap_q   <= lap_q + LW'(len_q);
          lap_i_q <= lap_i_q + 1'b1;
          state_q <= S_LAP;
        end
        S_SEG0: state_q <= S_SEG1;
        S_SEG1: begin
          pa_x_q  <= ram_rdata[31:0];
          pa_z_q  <= ram_rdata[63:32];
          state_q <= S_SEG2;
        end
        S_SEG2: begin
          hx_q      <= {{2{ram_rdata[31]}}, ram_rdata[31:0]} - {{2{pa_x_q[31]}}, pa_x_q};
          hz_q      <= {{2{ram_rdata[63]}}, ram_rdata[63:32]} - {{2{pa_z_q[31]}}, pa_z_q};
          hyp_ret_q <= S_SEGRET;
          state_q   <= S_H0;
        end
        S_H0: begin
          half_q  <= halve;
          ha_q    <= halve ? ax[32:1] : ax[31:0];
          hb_q    <= halve ? az[32:1] : az[31:0];
          state_q <= S_H1;
        end
        S_H1: begin
          sqa_q   <= ha_q * ha_q;
          state_q <= S_H2;
        end
        S_H2: begin
          sqb_q   <= hb_q * hb_q;
          state_q <= S_H3;
        end
        S_H3: begin
          sq_n_q   <= sqa_q + sqb_q;
          hyp_sq_q <= half_q ? '1 : sqa_q + sqb_q;
          sq_r_q   <= '0;
          sq_b_q   <= 64'd1 << 62;
          sq_cnt_q <= '0;
          state_q  <= S_SQ;
        end
        S_SQ: begin
          if (sq_n_q >= sq_trial) begin
            sq_n_q <= sq_n_q - sq_trial;
            sq_r_q <= (sq_r_q >> 1) + sq_b_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_b_q   <= sq_b_q >> 2;
          sq_cnt_q <= sq_cnt_q + 1'b1;
          if (sq_cnt_q == 5'd31) begin
            state_q <= hyp_ret_q;
          end
        end
        S_SEGRET: begin
          len_q   <= (hyp_sq_q < ZERO_SQ) ? '0 : hyp_len_q;
          state_q <= seg_ret_q;
        end
        S_WTOP: begin
          if (rem_q == '0) begin
            rd_cnt_q <= '0;
            state_q  <= S_SPLR;
          end else if (loop_q && (seg_t_q == '0) && (lap_q != '0)
                       && (LW'(rem_q) >= lap_q)) begin
            div_num_q <= 64'(rem_q);
            div_den_q <= 64'(lap_q);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            div_ret_q <= S_MODRET;
            state_q   <= S_DIV;
          end else begin
            seg_i_q   <= seg_idx_q;
            seg_ret_q <= S_WLEN;
            state_q   <= S_SEG0;
          end
        end
        S_MODRET: begin
          rem_q <= div_rem_q[30:0];
          if (div_rem_q[30:0] == '0) begin
            rd_cnt_q <= '0;
            state_q  <= S_SPLR;
          end else begin
            seg_i_q   <= seg_idx_q;
            seg_ret_q <= S_WLEN;
            state_q   <= S_SEG0;
          end
        end
        S_WLEN: begin
          dend_q  <= wprod[50:16];
          state_q <= (len_q == '0) ? S_ADV : S_WCMP;
        end
        S_WCMP: begin
          skips_q <= '0;
          if (35'(rem_q) < dend_q) begin
            div_num_q <= {17'b0, rem_q, 16'b0};
            div_den_q <= 64'(len_q);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            div_ret_q <= S_WPART;
            state_q   <= S_DIV;
          end else begin
            rem_q   <= rem_q - 31'(dend_q);
            state_q <= S_ADV;
          end
        end
        S_WPART: begin
          seg_t_q  <= seg_t_q + 17'(div_num_q);
          rem_q    <= '0;
          rd_cnt_q <= '0;
          state_q  <= S_SPLR;
        end
        S_ADV: begin
          if (wrap && !loop_q) begin
            seg_idx_q <= AW'(segc_q - 1'b1);
            seg_t_q   <= T_ONE;
            rd_cnt_q  <= '0;
            state_q   <= S_SPLR;
          end else begin
            seg_t_q   <= '0;
            seg_idx_q <= wrap ? '0 : seg_idx_q + 1'b1;
            if ((len_q == '0) && ((int'(skips_q) + 1) >= int'(segc_q))) begin
              rd_cnt_q <= '0;
              state_q  <= S_SPLR;
            end else begin
              if (len_q == '0) begin
                skips_q <= skips_q + 1'b1;
              end
              state_q <= S_WTOP;
            end
          end
        end
        S_SPLR: begin
          if (rd_cnt_q != '0) begin
            px_q[rd_cnt_q[1:0] - 2'd1] <= ram_rdata[31:0];
            pz_q[rd_cnt_q[1:0] - 2'd1] <= ram_rdata[63:32];
          end
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (rd_cnt_q == 3'd4) begin
            axis_q  <= 1'b0;
            state_q <= S_COEF;
          end
        end
        S_COEF: begin
          a_q     <= coef_a;
          b_q     <= coef_b;
          p2x_q   <= q1 <<< 1;
          acc_q   <= coef_c;
          step_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= acc_q * $signed({1'b0, seg_t_q});
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= 40'(prod_q >>> 16) + addend;
          step_q  <= step_q + 1'b1;
          state_q <= (step_q == 2'd2) ? S_SAT : S_MUL;
        end
        S_SAT: begin
          if (!axis_q) begin
            nx_q    <= sat_v;
            axis_q  <= 1'b1;
            state_q <= S_COEF;
          end else begin
            nz_q    <= sat_v;
            state_q <= S_MOVE0;
          end
        end
        S_MOVE0: begin
          hx_q      <= {{2{nx_q[31]}}, nx_q} - {{2{pos_x_q[31]}}, pos_x_q};
          hz_q      <= {{2{nz_q[31]}}, nz_q} - {{2{pos_z_q[31]}}, pos_z_q};
          hyp_ret_q <= S_MOVE1;
          state_q   <= S_H0;
        end
        S_MOVE1: begin
          if ((hyp_sq_q > MOVE_SQ) && (hyp_len_q != '0)) begin
            div_num_q <= 64'(ax) << COORD_FRAC;
            div_den_q <= 64'(hyp_len_q);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            div_ret_q <= S_HX;
            state_q   <= S_DIV;
          end else begin
            state_q <= S_COMMIT;
          end
        end
        S_HX: begin
          hxn_q     <= hx_q[33] ? -$signed(cap_q) : $signed(cap_q);
          div_num_q <= 64'(az) << COORD_FRAC;
          div_den_q <= 64'(hyp_len_q);
          div_rem_q <= '0;
          div_cnt_q <= '0;
          div_ret_q <= S_HZ;
          state_q   <= S_DIV;
        end
        S_HZ: begin
          head_x_q <= hxn_q;
          head_z_q <= hz_q[33] ? -$signed(cap_q) : $signed(cap_q);
          state_q  <= S_COMMIT;
        end
        S_COMMIT: begin
          pos_x_q <= nx_q;
          pos_z_q <= nz_q;
          state_q <= S_FIN;
        end
        S_DIV: begin
          if (div_try >= {1'b0, div_den_q}) begin
            div_rem_q <= div_try - {1'b0, div_den_q};
            div_num_q <= {div_num_q[62:0], 1'b1};
          end else begin
            div_rem_q <= div_try;
            div_num_q <= {div_num_q[62:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 6'd63) begin
            state_q <= div_ret_q;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign hyp_len_q = half_q ? {sq_r_q[32:0], 1'b0} : sq_r_q[33:0];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) begin
      out_px_q  <= pos_x_q;
      out_pz_q  <= pos_z_q;
      out_dx_q  <= head_x_q[17:0];
      out_dz_q  <= head_z_q[17:0];
      out_seg_q <= 6'(seg_idx_q);
      out_t_q   <= seg_t_q;
      out_act_q <= active_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = out_px_q;
  assign pos_z_o        = out_pz_q;
  assign dir_x_o        = out_dx_q;
  assign dir_z_o        = out_dz_q;
  assign segment_now_o  = out_seg_q;
  assign seg_fraction_o = out_t_q;
  assign path_active_o  = out_act_q;

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op_i == OP_TICK)) |=> (state_q == S_INIT))
    else $error("tick beat did not start the walk");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_act_q) |-> (out_t_q <= T_ONE))
    else $error("segment fraction above one");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_x_q <= HMAX) && (head_x_q >= -HMAX) && (head_z_q <= HMAX) && (head_z_q >= -HMAX))
    else $error("heading component above unit length");

endmodule
